// ----- sv/lcg_pkg.sv -----
// Package: shared constants and types of the combination generator.
`default_nettype none
package lcg_pkg;

	localparam int MAX_SYMBOLS_DEF = 16;
	localparam int SYM_W           = 8;
	localparam int IDX_W           = 4;
	localparam int CNT_W           = 5;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_ADDR_W      = 5;

	typedef enum logic [1:0] {
		REG_SYMBOLS_LOW  = 2'd0,
		REG_SYMBOLS_HIGH = 2'd1,
		REG_PICK_COUNT   = 2'd2,
		REG_SET_SIZE     = 2'd3
	} reg_idx_t;

	// Control from the sequencer to the index unit.
	typedef struct packed {
		logic             load;
		logic             wr_en;
		logic             use_run;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] run;
		logic [CNT_W-1:0] k;
		logic [CNT_W-1:0] bias;
	} idx_ctl_t;

	// Status from the index unit back to the sequencer.
	typedef struct packed {
		logic [IDX_W-1:0] rd_idx;
		logic [IDX_W-1:0] inc;
		logic             less;
	} idx_stat_t;

endpackage
`default_nettype wire

// ----- sv/lcg_if.sv -----
// Interfaces: request and result channels of the combination generator.
`default_nettype none
interface lcg_req_if;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface lcg_res_if
	import lcg_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic [IDX_W-1:0] slot;
	logic             last;
	logic             has_more;
	logic             exhausted;
	modport source (output valid, output symbol, output slot, output last,
		output has_more, output exhausted, input ready);
	modport sink (input valid, input symbol, input slot, input last,
		input has_more, input exhausted, output ready);
endinterface
`default_nettype wire

// ----- sv/lexicographic_combination_generator.sv -----
// Top level: lexicographic k-of-n combination generator with APB configuration.
//
// The block steps through every k-element subset of the first n configured
// symbols in lexicographic order of their index tuples. A request with restart
// set loads the indices 0..k-1 and produces no result. A request with restart
// clear produces k results, one per symbol of the current combination (slot
// 0..k-1, last on slot k-1, has_more on all of them unless it is the final
// combination), and moves to the next combination; once the combinations are
// used up, or when k is zero or above n, it produces one result flagged
// exhausted with symbol and slot zero. A next request runs a search, scanning
// positions from right to left through the single shared compare unit for the
// rightmost index that can still grow, then an emission of the k results,
// during which the same unit increments and refills the indices while the old
// symbols go out; the emission waits whenever the result channel stalls. The
// block takes no request until all results of the current one are in the
// output register. Registers sit at byte address 8*i on a 64-bit APB port:
// symbols_low, symbols_high, pick_count, set_size. Write them only while the
// block is idle. n saturates at MAX_SYMBOLS.
`default_nettype none
module lexicographic_combination_generator
	import lcg_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lcg_req_if.sink                    req,
	lcg_res_if.source                  res,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_EXH    = 4'b1000
	} state_t;

	// Configuration registers
	logic [CFG_DATA_W-1:0] symbols_low_q;
	logic [CFG_DATA_W-1:0] symbols_high_q;
	logic [CNT_W-1:0]      pick_count_q;
	logic [CNT_W-1:0]      set_size_q;

	reg_idx_t reg_sel;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
			pick_count_q   <= CNT_W'(1);
			set_size_q     <= CNT_W'(16);
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_SYMBOLS_LOW:  symbols_low_q  <= pwdata;
				REG_SYMBOLS_HIGH: symbols_high_q <= pwdata;
				REG_PICK_COUNT:   pick_count_q   <= pwdata[CNT_W-1:0];
				REG_SET_SIZE:     set_size_q     <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SYMBOLS_LOW:  prdata = symbols_low_q;
			REG_SYMBOLS_HIGH: prdata = symbols_high_q;
			REG_PICK_COUNT:   prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, pick_count_q};
			REG_SET_SIZE:     prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, set_size_q};
			default:          prdata = '0;
		endcase
	end

	// Effective k and n; a combination exists only for 1 <= k <= n.
	localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_SYMBOLS);

	logic [CNT_W-1:0] eff_n;
	logic [CNT_W-1:0] eff_k;
	logic             combo_ok;

	assign eff_n    = (set_size_q > N_MAX) ? N_MAX : set_size_q;
	assign eff_k    = pick_count_q;
	assign combo_ok = (eff_k != '0) && (eff_k <= eff_n);

	// Sequencer state
	state_t           state_q;
	logic             more_left_q;
	logic             found_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] pivot_q;
	logic [IDX_W-1:0] run_q;

	// Output register
	logic             res_valid_q;
	logic [SYM_W-1:0] symbol_q;
	logic [IDX_W-1:0] slot_q;
	logic             last_q;
	logic             has_more_q;
	logic             exhausted_q;

	idx_ctl_t  ctl;
	idx_stat_t stat;

	logic                 req_fire;
	logic                 out_free;
	logic                 pos_last;
	logic [2*CFG_DATA_W-1:0] sym_vec;
	logic [SYM_W-1:0]     cur_symbol;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign out_free   = !res_valid_q || res.ready;
	assign pos_last   = ({1'b0, pos_q} + CNT_W'(1)) == eff_k;
	assign sym_vec    = {symbols_high_q, symbols_low_q};
	assign cur_symbol = sym_vec[{stat.rd_idx, 3'b000} +: SYM_W];

	// Drive the shared unit: compare during search, increment/refill while emitting.
	always_comb begin
		ctl.load    = req_fire && req.restart;
		ctl.wr_en   = (state_q == ST_EMIT) && out_free && found_q && (pos_q >= pivot_q);
		ctl.use_run = (pos_q != pivot_q);
		ctl.pos     = pos_q;
		ctl.run     = run_q;
		ctl.k       = eff_k;
		ctl.bias    = eff_n - eff_k;
	end

	lcg_index_unit #(
		.DEPTH (MAX_SYMBOLS)
	) u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			more_left_q <= 1'b0;
			found_q     <= 1'b0;
			pos_q       <= '0;
			pivot_q     <= '0;
			run_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.restart) begin
							more_left_q <= combo_ok;
						end else if (!more_left_q || !combo_ok) begin
							more_left_q <= 1'b0;
							state_q     <= ST_EXH;
						end else begin
							// Scan from the rightmost position.
							pos_q   <= IDX_W'(eff_k - CNT_W'(1));
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (stat.less) begin
						found_q <= 1'b1;
						pivot_q <= pos_q;
						pos_q   <= '0;
						state_q <= ST_EMIT;
					end else if (pos_q == '0) begin
						found_q <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						pos_q <= pos_q - IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (ctl.wr_en) run_q <= stat.inc;
						if (pos_last) begin
							more_left_q <= found_q;
							state_q     <= ST_IDLE;
						end else begin
							pos_q <= pos_q + IDX_W'(1);
						end
					end
				end
				ST_EXH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: load when free, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= (state_q == ST_EMIT) || (state_q == ST_EXH);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_EXH) begin
				symbol_q    <= '0;
				slot_q      <= '0;
				last_q      <= 1'b1;
				has_more_q  <= 1'b0;
				exhausted_q <= 1'b1;
			end else begin
				symbol_q    <= cur_symbol;
				slot_q      <= pos_q;
				last_q      <= pos_last;
				has_more_q  <= found_q;
				exhausted_q <= 1'b0;
			end
		end
	end

	assign res.valid     = res_valid_q;
	assign res.symbol    = symbol_q;
	assign res.slot      = slot_q;
	assign res.last      = last_q;
	assign res.has_more  = has_more_q;
	assign res.exhausted = exhausted_q;

endmodule
`default_nettype wire

// ----- sv/lcg_index_unit.sv -----
// Index unit: the chosen-index registers and the shared compare/increment unit.
`default_nettype none
module lcg_index_unit
	import lcg_pkg::*;
#(
	parameter int DEPTH = MAX_SYMBOLS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire idx_ctl_t  ctl,
	output idx_stat_t      stat
);

	localparam int AW = $clog2(DEPTH);

	logic [IDX_W-1:0] chosen_q [DEPTH];
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] opnd;
	logic [CNT_W-1:0] bound;

	assign rd_idx = chosen_q[ctl.pos[AW-1:0]];
	assign opnd   = ctl.use_run ? ctl.run : rd_idx;
	assign bound  = ctl.bias + {1'b0, ctl.pos};

	assign stat.rd_idx = rd_idx;
	assign stat.inc    = opnd + IDX_W'(1);
	assign stat.less   = {1'b0, rd_idx} < bound;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) chosen_q[i] <= '0;
		end else if (ctl.load) begin
			// Load 0..k-1 and clear the tail.
			for (int i = 0; i < DEPTH; i++) begin
				chosen_q[i] <= (CNT_W'(i) < ctl.k) ? IDX_W'(i) : '0;
			end
		end else if (ctl.wr_en) begin
			chosen_q[ctl.pos[AW-1:0]] <= stat.inc;
		end
	end

endmodule
`default_nettype wire

// ----- sv/lcg_checker.sv -----
// Checker: port-level properties of the combination generator, bound to the top level.
`default_nettype none
module lcg_checker
	import lcg_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             req_restart,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire logic [SYM_W-1:0] res_symbol,
	input wire logic [IDX_W-1:0] res_slot,
	input wire logic             res_last,
	input wire logic             res_has_more,
	input wire logic             res_exhausted
);

	// An exhausted answer is a single, empty, final transaction.
	a_exh_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_exhausted |->
			res_symbol == '0 && res_slot == '0 && res_last && !res_has_more)
		else $error("exhausted result malformed");

	// A next request holds off further requests while it works.
	a_next_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_restart |=> !req_ready)
		else $error("ready stayed high after a next request");

	// A restart completes at once and produces no result.
	a_restart_quick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_restart |=> req_ready)
		else $error("restart did not return to ready");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_symbol) && $stable(res_slot))
		else $error("stalled result changed");

endmodule

bind lexicographic_combination_generator lcg_checker u_lcg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_restart   (req.restart),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_symbol    (res.symbol),
	.res_slot      (res.slot),
	.res_last      (res.last),
	.res_has_more  (res.has_more),
	.res_exhausted (res.exhausted)
);
`default_nettype wire

// ----- sim/lexicographic_combination_generator_test.sv -----
`timescale 1ns / 1ps
// Testbench: drives k-of-n enumeration requests and APB writes, checks each symbol result.
module lexicographic_combination_generator_test;
	import lcg_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int ITEM_TARGET   = 260;
	// Settle time for the longest next request, with k up to 16, plus margin.
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 240;
	localparam int CYCLE_LIMIT   = 500000;

	// One symbol transaction as it leaves the block.
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [IDX_W-1:0] slot;
		logic             last;
		logic             has_more;
		logic             exhausted;
	} comb_result_t;

	typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

	// One row of the directed table: either a register write or a request.
	// Rows marked typed carry their single expected transaction by hand.
	typedef struct {
		row_kind_t             kind;
		reg_idx_t              sel;
		logic [CFG_DATA_W-1:0] value;
		logic                  restart;
		bit                    typed;
		comb_result_t          want;
	} stim_row_t;

	// The answer to a next request once nothing is left to enumerate.
	localparam comb_result_t EXHAUSTED_RESULT = {8'h00, 4'h0, 1'b1, 1'b0, 1'b1};

	// Directed symbol sets: low byte of the low word is all ones, a zero byte in the high word.
	localparam logic [CFG_DATA_W-1:0] DIR_SYM_LOW  = 64'h7F80_01FE_AA55_C3FF;
	localparam logic [CFG_DATA_W-1:0] DIR_SYM_HIGH = 64'h00E7_1824_9966_5A81;
	// With k = 1 after a restart, the first combination is symbol 0 alone.
	localparam comb_result_t FIRST_OF_DIR  = {8'hFF, 4'h0, 1'b1, 1'b1, 1'b0};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	lcg_req_if req_ch();
	lcg_res_if res_ch();

	lexicographic_combination_generator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Shadow of the block's registers and enumeration state.
	logic [CFG_DATA_W-1:0] sym_low_m;
	logic [CFG_DATA_W-1:0] sym_high_m;
	logic [CNT_W-1:0]      pick_m;
	logic [CNT_W-1:0]      size_m;
	logic [IDX_W-1:0]      chosen[16];
	bit                    combos_pending;

	// Transactions the block still owes, oldest first, and the latest prediction.
	comb_result_t expected_symbols[$];
	comb_result_t predicted[$];

	int fail_count;
	int requests_sent;
	int restarts_sent;
	int symbols_checked;
	int exhausted_seen;
	int writes_done;
	int cycle_count;

	// Knobs shared between the stimulus and the result sink.
	bit send_idle_on;
	bit recv_idle_on;
	int hold_request;

	// Work out what one accepted request produces and advance the shadow indices.
	function automatic void predict_combination(input logic restart);
		int n;
		int k;
		int lim;
		bit ok;
		bit found;
		logic [SYM_W-1:0] syms[16];
		comb_result_t r;
		// n saturates at the symbol store size; k is taken as written.
		n = (size_m > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : int'(size_m);
		k = int'(pick_m);
		ok = (k >= 1) && (k <= n);
		predicted.delete();
		if (restart) begin
			// Load 0..k-1, clear the rest; nothing goes out.
			lim = (k > 16) ? 16 : k;
			for (int i = 0; i < 16; i++)
				chosen[i] = (i < lim) ? IDX_W'(i) : '0;
			combos_pending = ok;
		end else if (!combos_pending || !ok) begin
			combos_pending = 1'b0;
			predicted.insert(predicted.size(), EXHAUSTED_RESULT);
		end else begin
			// Latch the symbols of the current combination before stepping.
			for (int i = 0; i < k; i++)
				syms[i] = chosen[i][3] ? sym_high_m[chosen[i][2:0]*8 +: 8]
					: sym_low_m[chosen[i][2:0]*8 +: 8];
			// Grow the rightmost index still below its bound, refill to its right.
			found = 1'b0;
			for (int t = k; t > 0; t--) begin
				if (!found && int'(chosen[t-1]) < n - k + t - 1) begin
					chosen[t-1] = chosen[t-1] + 1'b1;
					for (int m = t; m < k; m++)
						chosen[m] = chosen[m-1] + 1'b1;
					found = 1'b1;
				end
			end
			combos_pending = found;
			for (int i = 0; i < k; i++) begin
				r.symbol    = syms[i];
				r.slot      = IDX_W'(i);
				r.last      = (i == k - 1);
				r.has_more  = found;
				r.exhausted = 1'b0;
				predicted.insert(predicted.size(), r);
			end
		end
	endfunction

	function automatic stim_row_t req_row(input logic restart, input bit typed = 1'b0,
			input comb_result_t want = EXHAUSTED_RESULT);
		stim_row_t row;
		row.kind    = ROW_REQUEST;
		row.sel     = REG_SYMBOLS_LOW;
		row.value   = '0;
		row.restart = restart;
		row.typed   = typed;
		row.want    = want;
		return row;
	endfunction

	function automatic stim_row_t write_row(input reg_idx_t sel,
			input logic [CFG_DATA_W-1:0] value);
		stim_row_t row;
		row.kind    = ROW_WRITE;
		row.sel     = sel;
		row.value   = value;
		row.restart = 1'b0;
		row.typed   = 1'b0;
		row.want    = EXHAUSTED_RESULT;
		return row;
	endfunction

	// Offer one request; called at a falling edge, returns at a falling edge once the request is taken,
	// with valid still high so a following request can go back to back.
	task automatic send_request(input logic restart, input bit typed, input comb_result_t want);
		int gap;
		if (send_idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.restart <= restart;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_combination(restart);
		if (typed)
			expected_symbols.insert(expected_symbols.size(), want);
		else
			foreach (predicted[i])
				expected_symbols.insert(expected_symbols.size(), predicted[i]);
		requests_sent++;
		if (restart)
			restarts_sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed transaction, then let a restart finish too.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (expected_symbols.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write: setup phase, access phase, then idle.
	task automatic write_register(input reg_idx_t sel, input logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (sel)
			REG_SYMBOLS_LOW:  sym_low_m  = value;
			REG_SYMBOLS_HIGH: sym_high_m = value;
			REG_PICK_COUNT:   pick_m     = value[CNT_W-1:0];
			REG_SET_SIZE:     size_m     = value[CNT_W-1:0];
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Result sink: random stall bursts, plus one long hold-off when asked for.
	initial begin : result_sink
		int gap;
		int hold;
		gap = 0;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				res_ch.ready <= 1'b0;
			end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(0, 6);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Compare every accepted transaction against the oldest expectation.
	always @(posedge clk) begin : result_check
		comb_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_symbols.size() == 0) begin
				$error("unexpected transaction: symbol %0h slot %0d exhausted %0b",
					res_ch.symbol, res_ch.slot, res_ch.exhausted);
				fail_count++;
			end else begin
				want = expected_symbols.pop_front();
				if (res_ch.symbol !== want.symbol) begin
					$error("symbol: expected %0h, actual %0h", want.symbol, res_ch.symbol);
					fail_count++;
				end
				if (res_ch.slot !== want.slot) begin
					$error("slot: expected %0d, actual %0d", want.slot, res_ch.slot);
					fail_count++;
				end
				if (res_ch.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, res_ch.last);
					fail_count++;
				end
				if (res_ch.has_more !== want.has_more) begin
					$error("has_more: expected %0b, actual %0b", want.has_more, res_ch.has_more);
					fail_count++;
				end
				if (res_ch.exhausted !== want.exhausted) begin
					$error("exhausted: expected %0b, actual %0b",
						want.exhausted, res_ch.exhausted);
					fail_count++;
				end
				if (want.exhausted)
					exhausted_seen++;
				else
					symbols_checked++;
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t directed[$];
		int random_sent;
		int phase;
		int burst;
		int n_eff;
		bit well_formed;
		bit keep_indices;
		logic [CNT_W-1:0] n_new;
		logic [CNT_W-1:0] k_new;

		// Every input known from time zero; shadow follows the reset values.
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;
		sym_low_m      = '0;
		sym_high_m     = '0;
		pick_m         = CNT_W'(1);
		size_m         = CNT_W'(16);
		combos_pending = 1'b0;
		for (int i = 0; i < 16; i++)
			chosen[i] = '0;
		fail_count      = 0;
		requests_sent   = 0;
		restarts_sent   = 0;
		symbols_checked = 0;
		exhausted_seen  = 0;
		writes_done     = 0;
		cycle_count     = 0;
		hold_request    = 0;
		send_idle_on    = 1'b1;
		recv_idle_on    = 1'b1;

		// Directed table.
		// Next before any restart: nothing pending yet.
		directed.insert(directed.size(), req_row(1'b0, 1'b1, EXHAUSTED_RESULT));
		directed.insert(directed.size(), write_row(REG_SYMBOLS_LOW, DIR_SYM_LOW));
		directed.insert(directed.size(), write_row(REG_SYMBOLS_HIGH, DIR_SYM_HIGH));
		// k = 1 of n = 16: first combination is symbol 0.
		directed.insert(directed.size(), req_row(1'b1));
		directed.insert(directed.size(), req_row(1'b0, 1'b1, FIRST_OF_DIR));
		// k = n = 16: one combination with all slots, then used up.
		directed.insert(directed.size(), write_row(REG_PICK_COUNT, 64'd16));
		directed.insert(directed.size(), req_row(1'b1));
		directed.insert(directed.size(), req_row(1'b0));
		directed.insert(directed.size(), req_row(1'b0, 1'b1, EXHAUSTED_RESULT));
		// k = 0: no combinations at all.
		directed.insert(directed.size(), write_row(REG_PICK_COUNT, 64'd0));
		directed.insert(directed.size(), req_row(1'b1));
		directed.insert(directed.size(), req_row(1'b0, 1'b1, EXHAUSTED_RESULT));
		// k above the store size.
		directed.insert(directed.size(), write_row(REG_PICK_COUNT, 64'd20));
		directed.insert(directed.size(), req_row(1'b1));
		directed.insert(directed.size(), req_row(1'b0, 1'b1, EXHAUSTED_RESULT));
		// n written as 31 saturates at 16.
		directed.insert(directed.size(), write_row(REG_SET_SIZE, 64'd31));
		directed.insert(directed.size(), write_row(REG_PICK_COUNT, 64'd15));
		directed.insert(directed.size(), req_row(1'b1));
		directed.insert(directed.size(), req_row(1'b0));
		directed.insert(directed.size(), req_row(1'b0));
		// n = 0: k = 1 is above n.
		directed.insert(directed.size(), write_row(REG_SET_SIZE, 64'd0));
		directed.insert(directed.size(), write_row(REG_PICK_COUNT, 64'd1));
		directed.insert(directed.size(), req_row(1'b1));
		directed.insert(directed.size(), req_row(1'b0, 1'b1, EXHAUSTED_RESULT));
		// 3 of 5, then k rewritten to 2 without a restart.
		directed.insert(directed.size(), write_row(REG_SET_SIZE, 64'd5));
		directed.insert(directed.size(), write_row(REG_PICK_COUNT, 64'd3));
		directed.insert(directed.size(), req_row(1'b1));
		directed.insert(directed.size(), req_row(1'b0));
		directed.insert(directed.size(), req_row(1'b0));
		directed.insert(directed.size(), write_row(REG_PICK_COUNT, 64'd2));
		directed.insert(directed.size(), req_row(1'b0));
		directed.insert(directed.size(), req_row(1'b0));
		// n dropped below k mid-enumeration: exhausted and pending cleared.
		directed.insert(directed.size(), write_row(REG_SET_SIZE, 64'd1));
		directed.insert(directed.size(), req_row(1'b0, 1'b1, EXHAUSTED_RESULT));

		// Hold reset, release on a falling edge.
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				drain_results();
				write_register(directed[i].sel, directed[i].value);
			end else begin
				send_request(directed[i].restart, directed[i].typed, directed[i].want);
			end
		end

		// Random phases: each starts idle, picks a setting, then runs a burst.
		random_sent = 0;
		phase = 0;
		while (random_sent < ITEM_TARGET) begin
			drain_results();
			// Final quarter runs flat out on both sides.
			if (random_sent > ITEM_TARGET * 3 / 4) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end else begin
				send_idle_on = ($urandom_range(0, 3) != 0);
				recv_idle_on = ($urandom_range(0, 3) != 0);
			end

			// Mostly small n so enumerations run out; sometimes full or saturated.
			case ($urandom_range(0, 9))
				0:       n_new = CNT_W'($urandom_range(17, 31));
				1, 2:    n_new = CNT_W'(16);
				default: n_new = CNT_W'($urandom_range(1, 6));
			endcase
			n_eff = (n_new > 16) ? 16 : int'(n_new);
			case ($urandom_range(0, 9))
				0:       k_new = '0;
				1:       k_new = CNT_W'((n_eff + 1 > 31) ? 31 : n_eff + 1);
				2:       k_new = CNT_W'($urandom_range(17, 31));
				default: k_new = CNT_W'($urandom_range(1, n_eff));
			endcase

			// Now and then carry the stored indices into the new k and n.
			keep_indices = (phase > 0) && ($urandom_range(0, 5) == 0);
			if (!keep_indices) begin
				if (phase == 0 || $urandom_range(0, 1) == 0)
					write_register(REG_SYMBOLS_LOW, {$urandom, $urandom});
				if (phase == 0 || $urandom_range(0, 1) == 0)
					write_register(REG_SYMBOLS_HIGH, {$urandom, $urandom});
			end
			write_register(REG_SET_SIZE, CFG_DATA_W'(n_new));
			write_register(REG_PICK_COUNT, CFG_DATA_W'(k_new));

			// One phase holds the result side off while requests keep coming.
			if (phase == 2)
				hold_request = LONG_HOLD;

			well_formed = ($urandom_range(0, 4) != 0);
			burst = $urandom_range(3, 14);
			if (well_formed && !keep_indices) begin
				send_request(1'b1, 1'b0, EXHAUSTED_RESULT);
				random_sent++;
			end
			for (int b = 0; b < burst; b++) begin
				send_request(well_formed ? 1'b0 : 1'($urandom_range(0, 1)), 1'b0,
					EXHAUSTED_RESULT);
				random_sent++;
			end
			phase++;
		end

		// Let the pipeline empty, then give it time to show any stray transaction.
		req_ch.valid <= 1'b0;
		while (expected_symbols.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run: %0d requests (%0d restarts) over %0d register writes and %0d phases.",
			requests_sent, restarts_sent, writes_done, phase);
		$display("Checked %0d symbol transactions and %0d exhausted answers, %0d mismatches.",
			symbols_checked, exhausted_seen, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/lcg_pkg.sv
sv/lcg_if.sv
sv/lcg_index_unit.sv
sv/lexicographic_combination_generator.sv
sv/lcg_checker.sv
sim/lexicographic_combination_generator_test.sv
